// ===== src/wfa_pkg.sv =====
`timescale 1ns / 1ps

package wfa_pkg;

  localparam int MAX_FRAME_DEF      = 4096;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COS_TABLE_BITS_DEF = 10;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_BIT = 2;
  localparam int WTYPE_W     = 2;
  localparam int FLEN_W      = 13;

  localparam logic REG_WINDOW_TYPE  = 1'b0;
  localparam logic REG_FRAME_LENGTH = 1'b1;

  localparam logic [WTYPE_W-1:0] WIN_HANNING  = 2'd0;
  localparam logic [WTYPE_W-1:0] WIN_HAMMING  = 2'd1;
  localparam logic [WTYPE_W-1:0] WIN_TRIANGLE = 2'd2;
  localparam logic [WTYPE_W-1:0] WIN_BLACKMAN = 2'd3;

  localparam logic [WTYPE_W-1:0] WTYPE_RESET = WIN_HAMMING;
  localparam logic [FLEN_W-1:0]  FLEN_RESET  = 13'd1024;

  typedef struct packed {
    logic [WTYPE_W-1:0] window_type;
    logic [FLEN_W-1:0]  frame_length;
  } cfg_t;

  localparam int MUL_W     = 33;
  localparam int PROD_W    = 66;
  localparam int ACC_W     = 32;
  localparam int COS_W     = 17;
  localparam int COEF_W    = 17;
  localparam int SUM_W     = 48;
  localparam int TRI_SHIFT = 17;
  localparam int Q_SHIFT   = 30;
  localparam int Q15_SHIFT = 15;

  localparam logic [ACC_W-1:0]  ONE30     = 32'd1073741824;
  localparam logic [ACC_W-1:0]  HALF_Q15  = 32'd16384;
  localparam logic [COEF_W-1:0] COEF_ONE  = 17'd32768;
  localparam logic [SUM_W-1:0]  HALF_Q30  = 48'd536870912;

  localparam logic [2:0] CSTEP_SQUARE = 3'd0;
  localparam logic [2:0] CSTEP_K6     = 3'd1;
  localparam logic [2:0] CSTEP_LAST   = 3'd6;

  localparam logic [ACC_W-1:0] K_A1 = 32'd1324675879;
  localparam logic [ACC_W-1:0] K_A2 = 32'd272375560;
  localparam logic [ACC_W-1:0] K_A3 = 32'd22401991;
  localparam logic [ACC_W-1:0] K_A4 = 32'd987048;
  localparam logic [ACC_W-1:0] K_A5 = 32'd27060;
  localparam logic [ACC_W-1:0] K_A6 = 32'd506;

  localparam logic [31:0] WA_HANN = 32'd536870912;
  localparam logic [31:0] WA_HAMM = 32'd579820585;
  localparam logic [31:0] WA_BLK  = 32'd450971566;
  localparam logic [31:0] WB_HANN = 32'd536870912;
  localparam logic [31:0] WB_HAMM = 32'd493921239;
  localparam logic [31:0] WB_BLK  = 32'd536870912;
  localparam logic [31:0] WC_BLK  = 32'd85899346;

  function automatic logic [ACC_W-1:0] horner_k(input logic [2:0] step);
    logic [ACC_W-1:0] k;
    case (step)
      3'd1:    k = K_A5;
      3'd2:    k = K_A4;
      3'd3:    k = K_A3;
      3'd4:    k = K_A2;
      3'd5:    k = K_A1;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] win_a(input logic [WTYPE_W-1:0] wtype);
    logic [31:0] a;
    case (wtype)
      WIN_HANNING: a = WA_HANN;
      WIN_HAMMING: a = WA_HAMM;
      default:     a = WA_BLK;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] win_b(input logic [WTYPE_W-1:0] wtype);
    logic [31:0] b;
    case (wtype)
      WIN_HANNING: b = WB_HANN;
      WIN_HAMMING: b = WB_HAMM;
      default:     b = WB_BLK;
    endcase
    return b;
  endfunction

endpackage

// ===== src/wfa_if.sv =====
`timescale 1ns / 1ps

interface wfa_sample_if #(
  parameter int SAMPLE_BITS = wfa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface wfa_result_if #(
  parameter int SAMPLE_BITS = wfa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] windowed_sample;
  logic                          frame_end;

  modport source (output valid, output windowed_sample, output frame_end, input ready);
  modport sink (input valid, input windowed_sample, input frame_end, output ready);
endinterface

// ===== src/wfa_regs.sv =====
`timescale 1ns / 1ps

module wfa_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [wfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [wfa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output wfa_pkg::cfg_t                 cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_type  <= wfa_pkg::WTYPE_RESET;
      cfg.frame_length <= wfa_pkg::FLEN_RESET;
    end else if (wr) begin
      case (paddr[wfa_pkg::REG_IDX_BIT])
        wfa_pkg::REG_WINDOW_TYPE: begin
          cfg.window_type <= pwdata[wfa_pkg::WTYPE_W-1:0];
        end
        wfa_pkg::REG_FRAME_LENGTH: begin
          cfg.frame_length <= pwdata[wfa_pkg::FLEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[wfa_pkg::REG_IDX_BIT])
      wfa_pkg::REG_WINDOW_TYPE:  prdata = wfa_pkg::PDATA_W'(cfg.window_type);
      wfa_pkg::REG_FRAME_LENGTH: prdata = wfa_pkg::PDATA_W'(cfg.frame_length);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== src/wfa_div.sv =====
`timescale 1ns / 1ps

module wfa_div #(
  parameter int LEN_W = 13,
  parameter int IDX_W = 12,
  parameter int QUO_W = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [$clog2(QUO_W+1)-1:0]   steps,
  input  logic [IDX_W-1:0]             dividend,
  input  logic [LEN_W-1:0]             divisor,
  output logic                         done,
  output logic [QUO_W-1:0]             quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [LEN_W:0]   rem;
  logic [LEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   diff;
  logic             fits;

  assign shifted = {rem[LEN_W-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= (LEN_W+1)'(dividend);
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff : shifted;
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end

endmodule

// ===== src/wfa_mult.sv =====
`timescale 1ns / 1ps

module wfa_mult (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [wfa_pkg::MUL_W-1:0]   a,
  input  logic signed [wfa_pkg::MUL_W-1:0]   b,
  output logic signed [wfa_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== src/window_function_apply_unit.sv =====
`timescale 1ns / 1ps
// A new word is taken only while the unit is idle, after the previous result word has been
// written to the output, so words are not overlapped. The serial divider (one quotient bit a
// cycle) and the single shared 33x33 multiplier (seven products per cosine) set the pace.
// Synchronous reset selects Hamming with length 1024 and restarts the frame at position 0.
module window_function_apply_unit #(
  parameter int MAX_FRAME      = wfa_pkg::MAX_FRAME_DEF,
  parameter int SAMPLE_BITS    = wfa_pkg::SAMPLE_BITS_DEF,
  parameter int COS_TABLE_BITS = wfa_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [wfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [wfa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  wfa_sample_if.sink                    samples,
  wfa_result_if.source                  results
);

  localparam int LW  = $clog2(MAX_FRAME + 1);
  localparam int PW  = $clog2(MAX_FRAME);
  localparam int XW  = (LW > wfa_pkg::FLEN_W) ? LW : wfa_pkg::FLEN_W;
  localparam int P   = COS_TABLE_BITS;
  localparam int QW  = (P + 2 > wfa_pkg::TRI_SHIFT) ? P + 2 : wfa_pkg::TRI_SHIFT;
  localparam int CW  = $clog2(QW + 1);
  localparam int RW  = P - 2;
  localparam int TW  = P - 1;
  localparam int MW  = wfa_pkg::MUL_W;
  localparam int PRW = wfa_pkg::PROD_W;
  localparam int AW  = wfa_pkg::ACC_W;
  localparam int SW  = wfa_pkg::SUM_W;

  localparam logic signed [PRW-1:0] SMAX =
    {{(PRW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PRW-1:0] SMIN = ~SMAX;
  localparam logic signed [PRW-1:0] PRND = PRW'(wfa_pkg::HALF_Q15);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_CMUL = 4'd2;
  localparam logic [3:0] S_CUPD = 4'd3;
  localparam logic [3:0] S_WMUL = 4'd4;
  localparam logic [3:0] S_WUPD = 4'd5;
  localparam logic [3:0] S_CRND = 4'd6;
  localparam logic [3:0] S_SMUL = 4'd7;
  localparam logic [3:0] S_SUPD = 4'd8;

  wfa_pkg::cfg_t cfg;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [PW-1:0] position;
  logic [2:0]  cstep;
  logic        pass;
  logic        out_valid;
  logic        out_free;
  logic        accept;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          last_q;
  logic [P-1:0]                  kreg;
  logic [P-1:0]                  k2_q;
  logic [AW-1:0]                 v;
  logic [AW-1:0]                 acc;
  logic signed [wfa_pkg::COS_W-1:0] creg;
  logic signed [SW-1:0]          wsum;
  logic [wfa_pkg::COEF_W-1:0]    coef;

  logic [XW-1:0] flen_x;
  logic [XW-1:0] len_x;
  logic [LW-1:0] len;
  logic [LW-1:0] pos_x;
  logic [LW-1:0] idx;
  logic [LW-1:0] half;
  logic [LW-1:0] m_x;
  logic [LW-1:0] nxt_x;
  logic          is_last;
  logic          is_tri;
  logic          is_blk;

  logic          div_start;
  logic          div_done;
  logic [QW-1:0] quo;
  logic [QW:0]   yp1;
  logic [QW:0]   yp2;

  logic [1:0]    quad;
  logic [RW-1:0] rpart;
  logic [TW-1:0] tfold;
  logic [AW-1:0] uval;
  logic          cneg;

  logic                  mul_en;
  logic signed [MW-1:0]  mul_a;
  logic signed [MW-1:0]  mul_b;
  logic signed [PRW-1:0] prod;

  logic [AW-1:0]                 ph;
  logic [AW-1:0]                 cres;
  logic [wfa_pkg::COS_W-1:0]     cmag;
  logic signed [wfa_pkg::COS_W-1:0] cval;
  logic signed [SW-1:0]          wa;
  logic signed [SW-1:0]          wprod;
  logic [SW-1:0]                 wrnd;
  logic signed [PRW-1:0]         prnd;
  logic signed [PRW-1:0]         pshift;
  logic signed [SAMPLE_BITS-1:0] sat;

  wfa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    flen_x = XW'(cfg.frame_length);
    if (flen_x == '0) begin
      len_x = XW'(1);
    end else if (flen_x > XW'(MAX_FRAME)) begin
      len_x = XW'(MAX_FRAME);
    end else begin
      len_x = flen_x;
    end
    len    = len_x[LW-1:0];
    pos_x  = LW'(position);
    idx    = (pos_x >= len) ? '0 : pos_x;
    half   = len >> 1;
    is_tri = cfg.window_type == wfa_pkg::WIN_TRIANGLE;
    is_blk = cfg.window_type == wfa_pkg::WIN_BLACKMAN;
    if (idx > half) begin
      m_x = len - LW'(1) - idx;
    end else if (idx == half && is_tri && !len[0]) begin
      m_x = half - LW'(1);
    end else begin
      m_x = idx;
    end
    is_last = idx == len - LW'(1);
    nxt_x   = (idx + LW'(1) >= len) ? '0 : idx + LW'(1);
  end

  assign accept    = samples.valid && samples.ready;
  assign div_start = accept;

  wfa_div #(
    .LEN_W (LW),
    .IDX_W (PW),
    .QUO_W (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (is_tri ? CW'(wfa_pkg::TRI_SHIFT) : CW'(P + 2)),
    .dividend (m_x[PW-1:0]),
    .divisor  (len),
    .done     (div_done),
    .quotient (quo)
  );

  assign yp1 = {1'b0, quo} + (QW+1)'(1);
  assign yp2 = {1'b0, quo} + (QW+1)'(2);

  always_comb begin
    quad  = kreg[P-1:P-2];
    rpart = kreg[RW-1:0];
    tfold = quad[0] ? (TW'(1) << RW) - TW'(rpart) : TW'(rpart);
    uval  = AW'(tfold) << (AW - P);
    cneg  = quad[0] ^ quad[1];
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_CMUL: begin
        mul_en = 1'b1;
        if (cstep == wfa_pkg::CSTEP_SQUARE) begin
          mul_a = MW'(uval);
          mul_b = MW'(uval);
        end else if (cstep == wfa_pkg::CSTEP_K6) begin
          mul_a = MW'(wfa_pkg::K_A6);
          mul_b = MW'(v);
        end else begin
          mul_a = MW'(acc);
          mul_b = MW'(v);
        end
      end
      S_WMUL: begin
        mul_en = 1'b1;
        mul_a  = pass ? MW'(wfa_pkg::WC_BLK) : MW'(wfa_pkg::win_b(cfg.window_type));
        mul_b  = MW'(creg);
      end
      S_SMUL: begin
        mul_en = 1'b1;
        mul_a  = MW'(sample_q);
        mul_b  = MW'(coef);
      end
      default: begin
      end
    endcase
  end

  wfa_mult u_mult (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    ph    = prod[wfa_pkg::Q_SHIFT+AW-1:wfa_pkg::Q_SHIFT];
    cres  = (ph >= wfa_pkg::ONE30) ? '0 : wfa_pkg::ONE30 - ph;
    cmag  = wfa_pkg::COS_W'((cres + wfa_pkg::HALF_Q15) >> wfa_pkg::Q15_SHIFT);
    cval  = cneg ? -$signed(cmag) : $signed(cmag);
    wa    = $signed(SW'(wfa_pkg::win_a(cfg.window_type)) << wfa_pkg::Q15_SHIFT);
    wprod = prod[SW-1:0];
    wrnd  = wsum + wfa_pkg::HALF_Q30;
    prnd  = prod + PRND;
    pshift = prnd >>> wfa_pkg::Q15_SHIFT;
    if (pshift > SMAX) begin
      sat = SMAX[SAMPLE_BITS-1:0];
    end else if (pshift < SMIN) begin
      sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sat = pshift[SAMPLE_BITS-1:0];
    end
  end

  assign out_free      = !out_valid || results.ready;
  assign samples.ready = state == S_IDLE;
  assign results.valid = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = is_tri ? S_SMUL : S_CMUL;
        end
      end
      S_CMUL: begin
        state_next = S_CUPD;
      end
      S_CUPD: begin
        state_next = (cstep == wfa_pkg::CSTEP_LAST) ? S_WMUL : S_CMUL;
      end
      S_WMUL: begin
        state_next = S_WUPD;
      end
      S_WUPD: begin
        state_next = (!pass && is_blk) ? S_CMUL : S_CRND;
      end
      S_CRND: begin
        state_next = S_SMUL;
      end
      S_SMUL: begin
        state_next = S_SUPD;
      end
      S_SUPD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      position  <= '0;
      cstep     <= '0;
      pass      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        position <= nxt_x[PW-1:0];
      end
      if (state == S_DIV && div_done) begin
        cstep <= wfa_pkg::CSTEP_SQUARE;
        pass  <= 1'b0;
      end else if (state == S_CUPD && cstep != wfa_pkg::CSTEP_LAST) begin
        cstep <= cstep + 3'd1;
      end else if (state == S_WUPD && !pass && is_blk) begin
        cstep <= wfa_pkg::CSTEP_SQUARE;
        pass  <= 1'b1;
      end
      if (state == S_SUPD && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          sample_q <= samples.sample_in;
          last_q   <= is_last;
        end
      end
      S_DIV: begin
        if (div_done) begin
          coef <= wfa_pkg::COEF_W'(yp1[QW:1]);
          kreg <= yp2[P+1:2];
          k2_q <= yp1[P:1];
        end
      end
      S_CUPD: begin
        if (cstep == wfa_pkg::CSTEP_SQUARE) begin
          v <= ph;
        end else if (cstep == wfa_pkg::CSTEP_LAST) begin
          creg <= cval;
        end else begin
          acc <= wfa_pkg::horner_k(cstep) - ph;
        end
      end
      S_WUPD: begin
        wsum <= pass ? wsum + wprod : wa - wprod;
        if (!pass && is_blk) begin
          kreg <= k2_q;
        end
      end
      S_CRND: begin
        coef <= wsum[SW-1] ? '0 :
                wrnd[wfa_pkg::Q_SHIFT+wfa_pkg::COEF_W-1:wfa_pkg::Q_SHIFT];
      end
      S_SUPD: begin
        if (out_free) begin
          results.windowed_sample <= sat;
          results.frame_end       <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !samples.ready)
    else $error("input taken while a word is still in work");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> position == '0)
    else $error("position did not restart after the last word of a frame");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_coef_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SMUL |-> coef <= wfa_pkg::COEF_ONE)
    else $error("window coefficient above one");

  a_cstep_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMUL || state == S_CUPD) |-> cstep <= wfa_pkg::CSTEP_LAST)
    else $error("cosine step counter out of range");

endmodule
